### rtl/core/chd_pkg.sv
package chd_pkg;

	localparam int ROUNDS           = 16;
	localparam int BLOCK_BYTES      = 32;
	localparam int INIT_TRANSFORMS  = 1;
	localparam int FINAL_TRANSFORMS = 2;

	localparam int WORDS      = 32;
	localparam int HALF_WORDS = 16;
	localparam int HALF_STEPS = 2 * ROUNDS;
	localparam int HALF_W     = (HALF_STEPS > 1) ? $clog2(HALF_STEPS) : 1;

	localparam int XF_MAX = (INIT_TRANSFORMS > FINAL_TRANSFORMS) ? INIT_TRANSFORMS
		: FINAL_TRANSFORMS;
	localparam int XF_W   = $clog2(XF_MAX + 1);

	localparam int BLOCK_BITS = 8 * BLOCK_BYTES;
	localparam int POS_W      = $clog2(BLOCK_BITS);
	localparam int SUM_W      = POS_W + 1;

	localparam int ROT_A    = 7;
	localparam int ROT_B    = 11;
	localparam int SWAP_A_A = 8;
	localparam int SWAP_B_A = 2;
	localparam int SWAP_A_B = 4;
	localparam int SWAP_B_B = 1;

	localparam int HB_W              = 10;
	localparam logic [HB_W-1:0] HB_RESET = 10'd512;
	localparam logic [HB_W-1:0] HB_MIN   = 10'd8;
	localparam logic [HB_W-1:0] HB_MAX   = 10'd512;
	localparam int DIGEST_MAX_WORDS  = 16;
	localparam int NW_W              = $clog2(DIGEST_MAX_WORDS + 1);
	localparam int K_W               = $clog2(DIGEST_MAX_WORDS);

	localparam logic REQ_ABSORB = 1'b0;
	localparam logic REQ_FINISH = 1'b1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QA_W        = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic       fin;
		logic       block_end;
		logic [4:0] word;
		logic [1:0] lane;
		logic [7:0] data;
	} cmd_t;

	function automatic logic hb_ok(input logic [HB_W-1:0] v);
		return (v >= HB_MIN) && (v <= HB_MAX) && (v[2:0] == 3'b000);
	endfunction

	function automatic logic [NW_W-1:0] nwords(input logic [HB_W-1:0] hb);
		logic [HB_W:0] s;
		logic [HB_W-5:0] n;
		s = {1'b0, hb} + (HB_W+1)'(31);
		n = s[HB_W:5];
		if (n == '0)
			return NW_W'(1);
		if (n > (HB_W-4)'(DIGEST_MAX_WORDS))
			return NW_W'(DIGEST_MAX_WORDS);
		return NW_W'(n);
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned s);
		return (v << s) | (v >> (32 - s));
	endfunction

endpackage

### rtl/core/chd_if.sv
interface chd_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] message_byte;
	logic [3:0] bit_count;

	modport source(output valid, req_type, message_byte, bit_count, input ready);
	modport sink(input valid, req_type, message_byte, bit_count, output ready);
endinterface

interface chd_dig_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic        last_word;

	modport source(output valid, digest_word, last_word, input ready);
	modport sink(input valid, digest_word, last_word, output ready);
endinterface

### rtl/core/cubehash_16_32_digest.sv
// CubeHash16/32 streaming digest.
// request: one item per message byte (req_type absorb, bit_count 1..8, a
//   partial byte only last) or a finish item. Items are taken whenever the
//   four-entry command queue has room, so the front keeps accepting while
//   the round unit works.
// digest: after a finish, ceil(hash_bits/32) items of one 32-bit word each,
//   word 0 first, last_word set on the final one.
// cfg_we/cfg_wdata: hash_bits, 8..512 in steps of 8; other values are
//   dropped. A write re-initializes the state; write only while idle.
// Flow: an absorbed byte is XORed into the state as the back end pops
//   it; a full block adds one transform (one half round per cycle in the
//   shared round unit), during which the back end pops nothing.
//   A finish runs three transforms, then the digest words are emitted,
//   then a re-init transform runs before the next message is processed.
// Reset: the state is loaded with the IV and run through one transform;
//   items are queued meanwhile.
// A stalled receiver holds the emit sequence; the front keeps filling the
//   queue until it is full.
module cubehash_16_32_digest (
	input  logic                     clk,
	input  logic                     arst_n,
	chd_req_if.sink                  request,
	chd_dig_if.source                digest,
	input  logic                     cfg_we,
	input  logic [chd_pkg::HB_W-1:0] cfg_wdata
);
	import chd_pkg::*;

	cmd_t push_data;
	cmd_t pop_data;
	logic push;
	logic pop;
	logic full;
	logic empty;

	chd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	chd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	chd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_data  (pop_data),
		.empty     (empty),
		.pop       (pop),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.digest    (digest)
	);

endmodule

### rtl/core/chd_front.sv
module chd_front (
	input  logic                    clk,
	input  logic                    arst_n,
	chd_req_if.sink                 request,
	input  logic                    cfg_we,
	input  logic [chd_pkg::HB_W-1:0] cfg_wdata,
	output logic                    push,
	output chd_pkg::cmd_t           push_data,
	input  logic                    full
);
	import chd_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [3:0]       cnt_sat;
	logic [SUM_W-1:0] pos_sum;
	logic             acc;
	logic             is_fin;
	logic             absorb_ok;
	logic             block_end;

	assign request.ready = !full;
	assign acc           = request.valid && !full;
	assign is_fin        = (request.req_type == REQ_FINISH);
	assign cnt_sat       = (request.bit_count > 4'd8) ? 4'd8 : request.bit_count;
	assign pos_sum       = {1'b0, pos_q} + SUM_W'(cnt_sat);
	assign absorb_ok     = (request.bit_count != 4'd0) && (pos_q[2:0] == 3'b000);
	assign block_end     = (pos_sum >= SUM_W'(BLOCK_BITS));

	assign push = acc && (is_fin || absorb_ok);

	always_comb begin
		push_data.fin       = is_fin;
		push_data.block_end = block_end;
		push_data.word      = 5'(({5'b0, pos_q}) >> 5);
		push_data.lane      = 2'(({5'b0, pos_q}) >> 3);
		push_data.data      = is_fin ? (8'h80 >> pos_q[2:0]) : request.message_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cfg_we && hb_ok(cfg_wdata)) begin
			pos_q <= '0;
		end else if (acc) begin
			if (is_fin) begin
				pos_q <= '0;
			end else if (absorb_ok) begin
				pos_q <= block_end ? '0 : pos_sum[POS_W-1:0];
			end
		end
	end

endmodule

### rtl/core/chd_queue.sv
module chd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  chd_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output chd_pkg::cmd_t pop_data,
	output logic          empty
);
	import chd_pkg::*;

	cmd_t            mem_q [QUEUE_DEPTH];
	logic [QA_W-1:0] wr_q;
	logic [QA_W-1:0] rd_q;
	logic [QA_W:0]   cnt_q;

	assign full     = (cnt_q == (QA_W+1)'(QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + QA_W'(1);
			if (pop)
				rd_q <= rd_q + QA_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (QA_W+1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (QA_W+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QA_W+1)'(QUEUE_DEPTH))
		else $error("queue count over depth");

endmodule

### rtl/core/chd_back.sv
module chd_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  chd_pkg::cmd_t            pop_data,
	input  logic                     empty,
	output logic                     pop,
	input  logic                     cfg_we,
	input  logic [chd_pkg::HB_W-1:0] cfg_wdata,
	chd_dig_if.source                digest
);
	import chd_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;
	localparam logic [1:0] S_LOAD = 2'd3;

	logic [31:0]     st_q [WORDS];
	logic [31:0]     st_d [WORDS];
	logic [31:0]     rnd  [WORDS];
	logic [31:0]     bsum [HALF_WORDS];
	logic [1:0]      fsm_q;
	logic [HALF_W-1:0] half_q;
	logic [XF_W-1:0] xf_q;
	logic            fin_q;
	logic [K_W-1:0]  k_q;
	logic [HB_W-1:0] hb_q;
	logic            out_valid_q;
	logic [31:0]     out_word_q;
	logic            out_last_q;
	logic [NW_W-1:0] nw;
	logic            last;
	logic            xfer;
	logic            xf_end;

	assign pop    = (fsm_q == S_IDLE) && !empty;
	assign nw     = nwords(hb_q);
	assign last   = (NW_W'(k_q) == nw - NW_W'(1));
	assign xfer   = (fsm_q == S_EMIT) && (!out_valid_q || digest.ready);
	assign xf_end = (fsm_q == S_RUN) && (half_q == HALF_W'(HALF_STEPS - 1));

	assign digest.valid       = out_valid_q;
	assign digest.digest_word = out_word_q;
	assign digest.last_word   = out_last_q;

	// one half round per cycle
	always_comb begin
		for (int i = 0; i < HALF_WORDS; i++)
			bsum[i] = st_q[i + HALF_WORDS] + st_q[i];
		for (int i = 0; i < HALF_WORDS; i++) begin
			if (!half_q[0]) begin
				rnd[i]              = rotl32(st_q[i ^ SWAP_A_A], ROT_A) ^ bsum[i];
				rnd[i + HALF_WORDS] = bsum[i ^ SWAP_B_A];
			end else begin
				rnd[i]              = rotl32(st_q[i ^ SWAP_A_B], ROT_B) ^ bsum[i];
				rnd[i + HALF_WORDS] = bsum[i ^ SWAP_B_B];
			end
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (fsm_q)
			S_IDLE: begin
				if (pop)
					st_d[pop_data.word] = st_q[pop_data.word]
						^ (32'(pop_data.data) << {pop_data.lane, 3'b000});
			end
			S_RUN: begin
				st_d = rnd;
				if (xf_end && fin_q && xf_q == XF_W'(FINAL_TRANSFORMS))
					st_d[WORDS-1][0] = ~rnd[WORDS-1][0];
			end
			S_EMIT: begin
				if (xfer) begin
					for (int i = 0; i < WORDS - 1; i++)
						st_d[i] = st_q[i + 1];
					st_d[WORDS-1] = '0;
				end
			end
			S_LOAD: begin
				for (int i = 0; i < WORDS; i++)
					st_d[i] = '0;
				st_d[0] = 32'(hb_q[HB_W-1:3]);
				st_d[1] = 32'(BLOCK_BYTES);
				st_d[2] = 32'(ROUNDS);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q       <= S_LOAD;
			half_q      <= '0;
			xf_q        <= '0;
			fin_q       <= 1'b0;
			k_q         <= '0;
			hb_q        <= HB_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && hb_ok(cfg_wdata)) begin
				hb_q  <= cfg_wdata;
				fsm_q <= S_LOAD;
			end else begin
				unique case (fsm_q)
					S_IDLE: begin
						if (pop) begin
							if (pop_data.fin) begin
								fsm_q <= S_RUN;
								fin_q <= 1'b1;
								xf_q  <= XF_W'(FINAL_TRANSFORMS);
							end else if (pop_data.block_end) begin
								fsm_q <= S_RUN;
								fin_q <= 1'b0;
								xf_q  <= '0;
							end
						end
					end
					S_RUN: begin
						if (xf_end) begin
							half_q <= '0;
							if (xf_q != '0) begin
								xf_q <= xf_q - XF_W'(1);
							end else if (fin_q) begin
								fsm_q <= S_EMIT;
								k_q   <= '0;
							end else begin
								fsm_q <= S_IDLE;
							end
						end else begin
							half_q <= half_q + HALF_W'(1);
						end
					end
					S_EMIT: begin
						if (xfer) begin
							k_q <= k_q + K_W'(1);
							if (last) begin
								fsm_q <= S_LOAD;
								fin_q <= 1'b0;
							end
						end
					end
					S_LOAD: begin
						fsm_q  <= S_RUN;
						half_q <= '0;
						xf_q   <= XF_W'(INIT_TRANSFORMS - 1);
						fin_q  <= 1'b0;
					end
					default: fsm_q <= S_LOAD;
				endcase
			end
			if (xfer)
				out_valid_q <= 1'b1;
			else if (digest.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		st_q <= st_d;
		if (xfer) begin
			out_word_q <= st_q[0];
			out_last_q <= last;
		end
	end

	a_idle_half: assert property (@(posedge clk) disable iff (!arst_n)
		fsm_q == S_IDLE |-> half_q == '0)
		else $error("half-round count not clear when idle");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(fsm_q) == S_EMIT)
		else $error("digest item raised outside emit");

	a_last_reinit: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && last |=> fsm_q == S_LOAD)
		else $error("no re-init after last digest word");

	a_emit_fin: assert property (@(posedge clk) disable iff (!arst_n)
		fsm_q == S_EMIT |-> fin_q)
		else $error("emit without finish");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

localparam int HALF_ROTS_A = 7;
localparam int HALF_ROTS_B = 11;
localparam int CUBE_ROUNDS = 16;
localparam int CUBE_BLOCK  = 32;
localparam int FINAL_XF    = 2;

class digest_board;
	bit [31:0]   cube [32];
	int unsigned pos;
	int unsigned len_bits;
	bit [32:0]   want_words [$];
	int unsigned fails;

	function new();
		len_bits = 512;
		fails = 0;
		load_iv();
	endfunction

	function void half_round(int unsigned rot, int unsigned sa, int unsigned sx);
		bit [31:0] t [16];
		int i;
		for (i = 0; i < 16; i++) cube[i + 16] += cube[i];
		for (i = 0; i < 16; i++) t[(i ^ sa) & 15] = cube[i];
		for (i = 0; i < 16; i++)
			cube[i] = ((t[i] << rot) | (t[i] >> (32 - rot))) ^ cube[i + 16];
		for (i = 0; i < 16; i++) t[(i ^ sx) & 15] = cube[i + 16];
		for (i = 0; i < 16; i++) cube[i + 16] = t[i];
	endfunction

	function void run_rounds();
		repeat (CUBE_ROUNDS) begin
			half_round(HALF_ROTS_A, 8, 2);
			half_round(HALF_ROTS_B, 4, 1);
		end
	endfunction

	function void load_iv();
		foreach (cube[i]) cube[i] = '0;
		cube[0] = len_bits / 8;
		cube[1] = CUBE_BLOCK;
		cube[2] = CUBE_ROUNDS;
		run_rounds();
		pos = 0;
	endfunction

	function void xor_in(bit [31:0] b);
		cube[(pos / 32) % 32] ^= b << (8 * ((pos / 8) % 4));
	endfunction

	function void set_length(bit [9:0] v);
		if (v < 8 || v > 512 || (v % 8) != 0) return;
		len_bits = 32'(v);
		load_iv();
	endfunction

	function void take_request(logic rt, logic [7:0] b, logic [3:0] c);
		int unsigned cnt;
		int unsigned n;
		int unsigned k;
		if (rt == chd_pkg::REQ_ABSORB) begin
			if (c == 0 || (pos % 8) != 0) return;
			cnt = (c > 8) ? 8 : c;
			xor_in({24'd0, b});
			pos += cnt;
			if (pos >= 8 * CUBE_BLOCK) begin
				run_rounds();
				pos = 0;
			end
			return;
		end
		xor_in(32'd128 >> (pos % 8));
		run_rounds();
		cube[31] ^= 32'd1;
		repeat (FINAL_XF) run_rounds();
		n = (len_bits + 31) / 32;
		if (n < 1) n = 1;
		if (n > 16) n = 16;
		for (k = 0; k < n; k++) want_words.push_back({k + 1 == n, cube[k]});
		load_iv();
	endfunction

	function void match_word(bit [31:0] w, bit l);
		bit [32:0] e;
		if (want_words.size() == 0) begin
			$error("unexpected digest item: digest_word %h last_word %0d", w, l);
			fails++;
			return;
		end
		e = want_words.pop_front();
		if (e[31:0] != w) begin
			$error("digest_word expected %h actual %h", e[31:0], w);
			fails++;
		end
		if (e[32] != l) begin
			$error("last_word expected %0d actual %0d", e[32], l);
			fails++;
		end
	endfunction

	function int pending();
		return want_words.size();
	endfunction
endclass

module tb;
	localparam int CYCLE_LIMIT = 600000;
	localparam int IDLE_WAIT   = 200;
	localparam int LONG_HOLD   = 400;
	localparam int PHASE_ITEMS = 4;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [chd_pkg::HB_W-1:0] cfg_wdata;

	chd_req_if req_bus();
	chd_dig_if dig_bus();

	cubehash_16_32_digest DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (req_bus),
		.digest   (dig_bus),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	digest_board board;
	int unsigned cycles = 0;
	int unsigned words_seen = 0;
	int unsigned taken;
	bit          src_fast;
	bit          snk_fast;

	int good_len [9] = '{8, 40, 256, 504, 16, 96, 488, 512, 72};
	int bad_len  [9] = '{1023, 0, 513, 7, 520, 1, 1000, 9, 511};

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && dig_bus.valid && dig_bus.ready)
			board.match_word(dig_bus.digest_word, dig_bus.last_word);

	initial begin
		int unsigned gap;
		dig_bus.ready = 1'b0;
		snk_fast = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 29) == 0) snk_fast = ~snk_fast;
			gap = snk_fast ? 0 : $urandom_range(0, 19);
			// long hold-off so the request queue fills and backs up
			if (words_seen == 20 || $urandom_range(0, 79) == 0) gap = LONG_HOLD;
			if (gap > 0) begin
				dig_bus.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			dig_bus.ready <= 1'b1;
			do @(posedge clk); while (!dig_bus.valid);
			words_seen++;
			@(negedge clk);
		end
	end

	task automatic send_req(input logic rt, input logic [7:0] b, input logic [3:0] c);
		int unsigned gap;
		gap = src_fast ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_bus.valid        <= 1'b1;
		req_bus.req_type     <= rt;
		req_bus.message_byte <= b;
		req_bus.bit_count    <= c;
		do @(posedge clk); while (!req_bus.ready);
		board.take_request(rt, b, c);
		@(negedge clk);
	endtask

	task automatic settle();
		req_bus.valid <= 1'b0;
		while (board.pending() != 0) @(negedge clk);
		repeat (IDLE_WAIT) @(negedge clk);
	endtask

	task automatic write_len(input logic [chd_pkg::HB_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		board.set_length(v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_message();
		int unsigned len;
		int unsigned k;
		logic [7:0]  b;
		logic [3:0]  c;
		bit          noisy;
		src_fast = ($urandom_range(0, 3) == 0);
		case ($urandom_range(0, 9))
			0: len = 32 * $urandom_range(1, 2);
			1, 2: len = $urandom_range(0, 100);
			default: len = $urandom_range(0, 40);
		endcase
		noisy = ($urandom_range(0, 7) == 0);
		for (k = 0; k < len; k++) begin
			c = 4'd8;
			if (noisy && $urandom_range(0, 5) == 0)
				c = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
			send_req(chd_pkg::REQ_ABSORB, 8'($urandom), c);
			if (c != 0) taken++;
		end
		if ($urandom_range(0, 3) == 0) begin
			c = 4'($urandom_range(1, 7));
			b = 8'($urandom);
			if ($urandom_range(0, 3) != 0) b = b & ~(8'hFF >> c);
			send_req(chd_pkg::REQ_ABSORB, b, c);
			taken++;
			if (noisy)
				send_req(chd_pkg::REQ_ABSORB, 8'($urandom), 4'($urandom_range(0, 15)));
		end
		send_req(chd_pkg::REQ_FINISH, 8'($urandom), 4'($urandom));
		taken++;
	endtask

	initial begin
		int p;
		board = new();
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_wdata            = '0;
		req_bus.valid        = 1'b0;
		req_bus.req_type     = chd_pkg::REQ_ABSORB;
		req_bus.message_byte = 8'd0;
		req_bus.bit_count    = 4'd0;
		src_fast             = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty message, extremes, zero and oversized counts, partial bytes
		send_req(chd_pkg::REQ_FINISH, 8'h00, 4'h0);
		send_req(chd_pkg::REQ_ABSORB, 8'hFF, 4'd8);
		send_req(chd_pkg::REQ_ABSORB, 8'h00, 4'd8);
		send_req(chd_pkg::REQ_ABSORB, 8'hA5, 4'd0);
		send_req(chd_pkg::REQ_ABSORB, 8'h3C, 4'd15);
		send_req(chd_pkg::REQ_ABSORB, 8'h80, 4'd1);
		send_req(chd_pkg::REQ_ABSORB, 8'h55, 4'd8);
		send_req(chd_pkg::REQ_FINISH, 8'hFF, 4'hF);
		send_req(chd_pkg::REQ_ABSORB, 8'hE7, 4'd3);
		send_req(chd_pkg::REQ_FINISH, 8'h00, 4'd8);
		send_req(chd_pkg::REQ_ABSORB, 8'hFE, 4'd7);
		send_req(chd_pkg::REQ_FINISH, 8'h5A, 4'd1);

		for (p = 0; p < 10; p++) begin
			if (p > 0) begin
				settle();
				write_len(10'(bad_len[p - 1]));
				@(negedge clk);
				write_len(10'(good_len[p - 1]));
			end
			taken = 0;
			while (taken < PHASE_ITEMS) send_message();
		end

		settle();
		if (board.fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
